// ----- hw/rtl/hsv_percent_to_rgb_percent_unit_defines.svh -----
// Assertion macros shared by the HSV to RGB percent converter.
`ifndef HSV_PERCENT_TO_RGB_PERCENT_UNIT_DEFINES_SVH
`define HSV_PERCENT_TO_RGB_PERCENT_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define HSV_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is high.
`define HSV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/hsvrgb_pkg.sv -----
// Constants and types for the HSV percent to RGB percent converter.
package hsvrgb_pkg;

   localparam int unsigned HUE_W     = 9;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 24;

   localparam logic [HUE_W-1:0]  HUE_MAX   = 9'd360;
   localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
   localparam logic [CHAN_W-1:0] SECTOR_SPAN = 8'd43;
   localparam logic [CHAN_W-1:0] SECTOR_STEP = 8'd6;

   // floor(x*255/360) = (x*46422) >> 16 for x <= 360
   localparam logic [15:0] HUE_MUL   = 16'd46422;
   localparam int unsigned HUE_SHIFT = 16;
   // floor(x*255/100) = (x*10445) >> 12 for x <= 100
   localparam logic [13:0] PCT_MUL   = 14'd10445;
   localparam int unsigned PCT_SHIFT = 12;
   // floor(c*100/255) = (c*25701) >> 16 for c <= 255
   localparam logic [14:0] OUT_MUL   = 15'd25701;
   localparam int unsigned OUT_SHIFT = 16;

   // Six hue sectors of the integer HSV rule.
   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

endpackage

// ----- hw/rtl/hsv_percent_to_rgb_percent_unit.sv -----
// Top level: six-stage HSV (degrees/percent) to RGB (percent) pipeline.
// Path: a taken beat is registered in stage 0 through stage 5 before it shows on rsp_*.
// Throughput: one beat per cycle while rsp_tready is high; each stage holds at most one multiplier row.
// Backpressure: each stage loads when empty or when the stage after it moves.
// Reset: synchronous, active high; clears the stage valid bits only.
// Payload registers are not reset; no state survives between beats.
`include "hsv_percent_to_rgb_percent_unit_defines.svh"

module hsv_percent_to_rgb_percent_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] power_on, [9:1] hue_degrees, [16:10] saturation_pct, [23:17] value_pct
   input  logic [hsvrgb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [6:0] red_pct, [13:7] green_pct, [20:14] blue_pct, [21] leds_enabled,
   // [23:22] zero
   output logic [hsvrgb_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int unsigned CW = hsvrgb_pkg::CHAN_W;
   localparam int unsigned PW = hsvrgb_pkg::PCT_W;

   // Stage valid bits and per-stage load enables.
   logic [5:0] vld_ff;
   logic [5:0] stage_en;

   // Unpack the request beat.
   logic                           req_power;
   logic [hsvrgb_pkg::HUE_W-1:0]   req_hue;
   logic [PW-1:0]                  req_sat;
   logic [PW-1:0]                  req_val;

   assign req_power = req_tdata[0];
   assign req_hue   = req_tdata[9:1];
   assign req_sat   = req_tdata[16:10];
   assign req_val   = req_tdata[23:17];

   // A stage loads when it is empty or its content moves on in this cycle.
   assign stage_en[5] = !vld_ff[5] || rsp_tready;
   assign stage_en[4] = !vld_ff[4] || stage_en[5];
   assign stage_en[3] = !vld_ff[3] || stage_en[4];
   assign stage_en[2] = !vld_ff[2] || stage_en[3];
   assign stage_en[1] = !vld_ff[1] || stage_en[2];
   assign stage_en[0] = !vld_ff[0] || stage_en[1];

   assign req_tready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) vld_ff[0] <= req_tvalid;
         if (stage_en[1]) vld_ff[1] <= vld_ff[0];
         if (stage_en[2]) vld_ff[2] <= vld_ff[1];
         if (stage_en[3]) vld_ff[3] <= vld_ff[2];
         if (stage_en[4]) vld_ff[4] <= vld_ff[3];
         if (stage_en[5]) vld_ff[5] <= vld_ff[4];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: clamp the inputs and scale all three to 0..255 with
   // reciprocal multiplies (exact floor over the clamped ranges).
   // ---------------------------------------------------------------------
   logic [hsvrgb_pkg::HUE_W-1:0] hue_clamp;
   logic [PW-1:0]                sat_clamp;
   logic [PW-1:0]                val_clamp;
   logic [24:0]                  hue_prod;
   logic [20:0]                  sat_prod;
   logic [20:0]                  val_prod;
   logic [CW-1:0]                hue0_in, sat0_in, val0_in;
   logic [CW-1:0]                hue0_ff, sat0_ff, val0_ff;
   logic                         pwr0_ff;

   assign hue_clamp = (req_hue > hsvrgb_pkg::HUE_MAX) ? hsvrgb_pkg::HUE_MAX : req_hue;
   assign sat_clamp = (req_sat > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : req_sat;
   assign val_clamp = (req_val > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : req_val;

   assign hue_prod = 25'(hue_clamp) * 25'(hsvrgb_pkg::HUE_MUL);
   assign sat_prod = 21'(sat_clamp) * 21'(hsvrgb_pkg::PCT_MUL);
   assign val_prod = 21'(val_clamp) * 21'(hsvrgb_pkg::PCT_MUL);

   assign hue0_in = hue_prod[hsvrgb_pkg::HUE_SHIFT +: CW];
   assign sat0_in = sat_prod[hsvrgb_pkg::PCT_SHIFT +: CW];
   assign val0_in = val_prod[hsvrgb_pkg::PCT_SHIFT +: CW];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pwr0_ff <= req_power;
         hue0_ff <= hue0_in;
         sat0_ff <= sat0_in;
         val0_ff <= val0_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: find the hue sector and its scaled remainder; form p.
   // ---------------------------------------------------------------------
   hsvrgb_pkg::sector_type sector1_in, sector1_ff;
   logic [CW-1:0]          sector_base;
   logic [5:0]             hue_off;
   logic [CW-1:0]          rem1_in, rem1_ff;
   logic [15:0]            p_prod;
   logic [CW-1:0]          p1_ff, sat1_ff, val1_ff;
   logic                   grey1_ff, pwr1_ff;

   always_comb begin
      if (hue0_ff < hsvrgb_pkg::SECTOR_SPAN) begin
         sector1_in  = hsvrgb_pkg::SECTOR_0;
         sector_base = 8'd0;
      end else if (hue0_ff < 8'(2 * hsvrgb_pkg::SECTOR_SPAN)) begin
         sector1_in  = hsvrgb_pkg::SECTOR_1;
         sector_base = 8'(hsvrgb_pkg::SECTOR_SPAN);
      end else if (hue0_ff < 8'(3 * hsvrgb_pkg::SECTOR_SPAN)) begin
         sector1_in  = hsvrgb_pkg::SECTOR_2;
         sector_base = 8'(2 * hsvrgb_pkg::SECTOR_SPAN);
      end else if (hue0_ff < 8'(4 * hsvrgb_pkg::SECTOR_SPAN)) begin
         sector1_in  = hsvrgb_pkg::SECTOR_3;
         sector_base = 8'(3 * hsvrgb_pkg::SECTOR_SPAN);
      end else if (hue0_ff < 8'(5 * hsvrgb_pkg::SECTOR_SPAN)) begin
         sector1_in  = hsvrgb_pkg::SECTOR_4;
         sector_base = 8'(4 * hsvrgb_pkg::SECTOR_SPAN);
      end else begin
         sector1_in  = hsvrgb_pkg::SECTOR_5;
         sector_base = 8'(5 * hsvrgb_pkg::SECTOR_SPAN);
      end
   end

   // Offset within a sector stays below 43, so times six fits in 8 bits.
   assign hue_off = 6'(hue0_ff - sector_base);
   assign rem1_in = 8'(hue_off) * hsvrgb_pkg::SECTOR_STEP;
   assign p_prod  = 16'(val0_ff) * 16'(hsvrgb_pkg::CHAN_FULL - sat0_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         pwr1_ff    <= pwr0_ff;
         sector1_ff <= sector1_in;
         rem1_ff    <= rem1_in;
         sat1_ff    <= sat0_ff;
         val1_ff    <= val0_ff;
         grey1_ff   <= (sat0_ff == '0);
         p1_ff      <= p_prod[15:8];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: saturation times remainder and times its complement.
   // ---------------------------------------------------------------------
   logic [15:0]            sr_prod, st_prod;
   logic [CW-1:0]          sr2_ff, st2_ff, p2_ff, val2_ff;
   hsvrgb_pkg::sector_type sector2_ff;
   logic                   grey2_ff, pwr2_ff;

   assign sr_prod = 16'(sat1_ff) * 16'(rem1_ff);
   assign st_prod = 16'(sat1_ff) * 16'(hsvrgb_pkg::CHAN_FULL - rem1_ff);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         pwr2_ff    <= pwr1_ff;
         sector2_ff <= sector1_ff;
         grey2_ff   <= grey1_ff;
         val2_ff    <= val1_ff;
         p2_ff      <= p1_ff;
         sr2_ff     <= sr_prod[15:8];
         st2_ff     <= st_prod[15:8];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: form q and t from the value.
   // ---------------------------------------------------------------------
   logic [15:0]            q_prod, t_prod;
   logic [CW-1:0]          q3_ff, t3_ff, p3_ff, val3_ff;
   hsvrgb_pkg::sector_type sector3_ff;
   logic                   grey3_ff, pwr3_ff;

   assign q_prod = 16'(val2_ff) * 16'(hsvrgb_pkg::CHAN_FULL - sr2_ff);
   assign t_prod = 16'(val2_ff) * 16'(hsvrgb_pkg::CHAN_FULL - st2_ff);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         pwr3_ff    <= pwr2_ff;
         sector3_ff <= sector2_ff;
         grey3_ff   <= grey2_ff;
         val3_ff    <= val2_ff;
         p3_ff      <= p2_ff;
         q3_ff      <= q_prod[15:8];
         t3_ff      <= t_prod[15:8];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: route v/p/q/t to the channels by sector; grey overrides.
   // ---------------------------------------------------------------------
   logic [CW-1:0] red4_in, green4_in, blue4_in;
   logic [CW-1:0] red4_ff, green4_ff, blue4_ff;
   logic          pwr4_ff;

   always_comb begin
      red4_in   = val3_ff;
      green4_in = val3_ff;
      blue4_in  = val3_ff;
      if (!grey3_ff) begin
         case (sector3_ff)
            hsvrgb_pkg::SECTOR_0: begin
               red4_in = val3_ff; green4_in = t3_ff;   blue4_in = p3_ff;
            end
            hsvrgb_pkg::SECTOR_1: begin
               red4_in = q3_ff;   green4_in = val3_ff; blue4_in = p3_ff;
            end
            hsvrgb_pkg::SECTOR_2: begin
               red4_in = p3_ff;   green4_in = val3_ff; blue4_in = t3_ff;
            end
            hsvrgb_pkg::SECTOR_3: begin
               red4_in = p3_ff;   green4_in = q3_ff;   blue4_in = val3_ff;
            end
            hsvrgb_pkg::SECTOR_4: begin
               red4_in = t3_ff;   green4_in = p3_ff;   blue4_in = val3_ff;
            end
            default: begin
               red4_in = val3_ff; green4_in = p3_ff;   blue4_in = q3_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         pwr4_ff   <= pwr3_ff;
         red4_ff   <= red4_in;
         green4_ff <= green4_in;
         blue4_ff  <= blue4_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: scale each channel back to percent; this is the output register.
   // ---------------------------------------------------------------------
   logic [22:0]   red_prod, green_prod, blue_prod;
   logic [PW-1:0] red5_ff, green5_ff, blue5_ff;
   logic          pwr5_ff;

   assign red_prod   = 23'(red4_ff)   * 23'(hsvrgb_pkg::OUT_MUL);
   assign green_prod = 23'(green4_ff) * 23'(hsvrgb_pkg::OUT_MUL);
   assign blue_prod  = 23'(blue4_ff)  * 23'(hsvrgb_pkg::OUT_MUL);

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         pwr5_ff   <= pwr4_ff;
         red5_ff   <= red_prod[hsvrgb_pkg::OUT_SHIFT +: PW];
         green5_ff <= green_prod[hsvrgb_pkg::OUT_SHIFT +: PW];
         blue5_ff  <= blue_prod[hsvrgb_pkg::OUT_SHIFT +: PW];
      end
   end

   assign rsp_tvalid = vld_ff[5];
   assign rsp_tdata  = {2'b00, pwr5_ff, blue5_ff, green5_ff, red5_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   logic pipe_stuck;
   logic pct_ok;
   logic grey_move;
   logic chan_flat;
   logic out_load;

   assign pipe_stuck = (vld_ff == 6'b111111) && !rsp_tready;
   assign pct_ok     = (red5_ff <= hsvrgb_pkg::PCT_MAX) &&
                       (green5_ff <= hsvrgb_pkg::PCT_MAX) &&
                       (blue5_ff <= hsvrgb_pkg::PCT_MAX);
   assign grey_move  = vld_ff[3] && grey3_ff && stage_en[4];
   assign chan_flat  = (red4_ff == green4_ff) && (green4_ff == blue4_ff);
   assign out_load   = vld_ff[4] && stage_en[5];

   `HSV_ASSERT_NOW(a_ready_drain, clock, reset, rsp_tready, req_tready, "input held on drain")
   `HSV_ASSERT_NOW(a_full_stall, clock, reset, pipe_stuck, !req_tready, "input taken into full pipe")
   `HSV_ASSERT_NOW(a_pct_range, clock, reset, rsp_tvalid, pct_ok, "channel percent above full scale")
   `HSV_ASSERT_NEXT(a_grey_flat, clock, reset, grey_move, chan_flat, "grey beat has unequal channels")
   `HSV_ASSERT_NEXT(a_last_advance, clock, reset, out_load, vld_ff[5], "beat lost at output")

endmodule
